[hw/rtl/sbc_pkg.sv]
// Shared types, widths and helpers for the sphere/box contact generator
package sbc_pkg;

	// Coordinate and vector widths
	localparam int CB  = 16;         // one coordinate component
	localparam int VW  = 3 * CB;     // packed position or size vector
	localparam int NW  = 16;         // one Q1.14 normal component
	localparam int NVW = 3 * NW;     // packed normal
	localparam int CW  = CB + 3;     // working width for signed coordinate sums
	localparam int OW  = CB + 2;     // signed overlap
	localparam int MW  = CB + 1;     // magnitude of a separation component
	localparam int RW  = CB + 1;     // radius (sum of two radii)
	localparam int SW  = 2 * MW;     // squared magnitude
	localparam int DSW = SW + 2;     // sum of three squares

	// Length has LEN_FRAC extra fraction bits
	localparam int LEN_FRAC  = 8;
	localparam int NORM_FRAC = 14;
	localparam int ROOT_W    = MW + LEN_FRAC;
	localparam int X_W       = 2 * ROOT_W;
	localparam int XPAD      = X_W - SW;
	localparam int REM_W     = ROOT_W + 2;
	localparam int SQ_STEPS  = ROOT_W;

	// Friction product goes through the root pipeline in its own lane, pre-scaled
	localparam int FP_W  = 32;
	localparam int F_PAD = X_W - FP_W;
	localparam int F_SH  = F_PAD / 2;

	// Normal division
	localparam int Q_BITS = NORM_FRAC + 1;
	localparam int NUM_SH = NORM_FRAC + LEN_FRAC;
	localparam int NUM_W  = MW + NUM_SH + 1;
	localparam int DEP_W  = ROOT_W + 2;

	localparam logic [NW-1:0] NORM_ONE = 16'h4000;
	localparam logic [15:0]   PEN_MAX  = 16'hFFFF;

	// Axis codes
	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;

	typedef enum logic [1:0] {
		PAIR_SS = 2'd0,
		PAIR_BB = 2'd1,
		PAIR_SB = 2'd2,
		PAIR_BS = 2'd3
	} pair_t;

	// One classified pair, handed from the front to the back
	typedef struct packed {
		logic                  hit;
		logic                  norm;       // normal needs normalising
		logic [2:0]            neg;        // sign of each normal component
		logic [2:0][MW-1:0]    mag;        // separation magnitudes
		logic [SW-1:0]         dsq;        // squared separation
		logic [RW-1:0]         rad;        // radius for depth
		logic [NVW-1:0]        fix_normal; // axis normal when not normalised
		logic [15:0]           fix_pen;
		logic [15:0]           rest;
		logic [FP_W-1:0]       fprod;
		logic                  sfirst;
	} job_t;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sq_res_t;

	// Axis of least overlap: x only if strictly smallest, then y, else z
	function automatic logic [1:0] pick_axis(input logic signed [OW-1:0] o0,
	                                         input logic signed [OW-1:0] o1,
	                                         input logic signed [OW-1:0] o2);
		logic [1:0] ax;
		if (o0 < o1 && o0 < o2) begin
			ax = AX_X;
		end else if (o1 < o0 && o1 < o2) begin
			ax = AX_Y;
		end else begin
			ax = AX_Z;
		end
		return ax;
	endfunction

	function automatic logic [NVW-1:0] axis_normal(input logic [1:0] ax, input logic neg);
		logic [NVW-1:0] n;
		logic [NW-1:0]  c;
		c = neg ? NW'(-NORM_ONE) : NORM_ONE;
		n = '0;
		case (ax)
			AX_X:    n[0 +: NW] = c;
			AX_Y:    n[NW +: NW] = c;
			default: n[2*NW +: NW] = c;
		endcase
		return n;
	endfunction

	// Saturate a signed overlap into the unsigned depth field
	function automatic logic [15:0] clamp_pen(input logic signed [OW-1:0] v);
		logic [15:0] p;
		if (v < 0) begin
			p = '0;
		end else if (v > $signed(OW'(PEN_MAX))) begin
			p = PEN_MAX;
		end else begin
			p = v[15:0];
		end
		return p;
	endfunction

	// One digit of the restoring square root
	function automatic sq_res_t sqrt_step(input logic [REM_W-1:0] rem_i,
	                                      input logic [ROOT_W-1:0] root_i,
	                                      input logic [1:0] pair);
		sq_res_t          r;
		logic [REM_W-1:0] r2;
		logic [REM_W-1:0] trial;
		r2    = {rem_i[REM_W-3:0], pair};
		trial = {root_i, 2'b01};
		if (r2 >= trial) begin
			r.rem  = r2 - trial;
			r.root = {root_i[ROOT_W-2:0], 1'b1};
		end else begin
			r.rem  = r2;
			r.root = {root_i[ROOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

[hw/rtl/sbc_front.sv]
// Front end: takes pairs, works out separation, overlaps and the hit test
module sbc_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic [47:0]        pos_a,
	input  logic [47:0]        pos_b,
	input  logic [47:0]        size_a,
	input  logic [47:0]        size_b,
	input  logic [15:0]        restitution_a,
	input  logic [15:0]        restitution_b,
	input  logic [15:0]        friction_a,
	input  logic [15:0]        friction_b,
	input  logic               q_full,
	output logic               push,
	output sbc_pkg::job_t      job
);

	logic en;

	// stage 1 combinational results
	logic [2:0][sbc_pkg::MW-1:0]     dmag_c;
	logic [2:0]                      dneg_c;
	logic [2:0]                      asgn_c;
	logic signed [sbc_pkg::OW-1:0]   ov_c [3];
	logic [sbc_pkg::RW-1:0]          rad_c;

	// stage 1 registers
	logic                            v_s1;
	logic [1:0]                      func_s1;
	logic [2:0][sbc_pkg::MW-1:0]     dmag_s1;
	logic [2:0]                      dneg_s1;
	logic [2:0]                      asgn_s1;
	logic signed [sbc_pkg::OW-1:0]   ov_s1 [3];
	logic [sbc_pkg::RW-1:0]          rad_s1;
	logic [15:0]                     cpen_s1;
	logic [15:0]                     rest_s1;
	logic [sbc_pkg::FP_W-1:0]        fprod_s1;

	// stage 2 registers
	logic                            v_s2;
	logic [1:0]                      func_s2;
	logic [2:0][sbc_pkg::MW-1:0]     dmag_s2;
	logic [sbc_pkg::SW-1:0]          sq_s2 [3];
	logic [sbc_pkg::SW-1:0]          rsq_s2;
	logic [2:0]                      dneg_s2;
	logic [2:0]                      asgn_s2;
	logic signed [sbc_pkg::OW-1:0]   ov_s2 [3];
	logic [sbc_pkg::RW-1:0]          rad_s2;
	logic [15:0]                     cpen_s2;
	logic [15:0]                     rest_s2;
	logic [sbc_pkg::FP_W-1:0]        fprod_s2;

	// stage 3
	logic                            v_s3;
	sbc_pkg::job_t                   job_c;
	sbc_pkg::job_t                   job_s3;

	// whole front moves unless the finished pair cannot enter the queue
	assign en       = !(v_s3 && q_full);
	assign in_stall = !en;
	assign push     = v_s3 && !q_full;
	assign job      = job_s3;

	// separation, box clamp and overlaps per axis
	always_comb begin
		logic signed [sbc_pkg::CW-1:0] pa, pb, ps, pc, pe, lo, hi, cq;
		logic signed [sbc_pkg::CW-1:0] dd, dc, bd, dn, add, abd, ovb, ovs;
		logic [sbc_pkg::CB-1:0]        sr;
		logic                          swp;
		swp = (func == sbc_pkg::PAIR_BS);
		sr  = swp ? size_b[sbc_pkg::CB-1:0] : size_a[sbc_pkg::CB-1:0];
		for (int i = 0; i < 3; i++) begin
			pa  = sbc_pkg::CW'($signed(pos_a[i*sbc_pkg::CB +: sbc_pkg::CB]));
			pb  = sbc_pkg::CW'($signed(pos_b[i*sbc_pkg::CB +: sbc_pkg::CB]));
			ps  = swp ? pb : pa;
			pc  = swp ? pa : pb;
			pe  = $signed(sbc_pkg::CW'(swp ? size_a[i*sbc_pkg::CB +: sbc_pkg::CB]
			                               : size_b[i*sbc_pkg::CB +: sbc_pkg::CB]));
			lo  = pc - pe;
			hi  = pc + pe;
			cq  = ps;
			if (cq < lo) cq = lo;
			if (cq > hi) cq = hi;
			dc  = ps - cq;
			dd  = pa - pb;
			bd  = ps - pc;
			dn  = (func == sbc_pkg::PAIR_SS) ? dd : dc;
			add = (dd < 0) ? -dd : dd;
			abd = (bd < 0) ? -bd : bd;
			ovb = $signed(sbc_pkg::CW'(size_a[i*sbc_pkg::CB +: sbc_pkg::CB]))
			    + $signed(sbc_pkg::CW'(size_b[i*sbc_pkg::CB +: sbc_pkg::CB])) - add;
			ovs = $signed(sbc_pkg::CW'(sr)) + pe - abd;
			dneg_c[i] = dn[sbc_pkg::CW-1];
			dmag_c[i] = sbc_pkg::MW'((dn < 0) ? -dn : dn);
			ov_c[i]   = sbc_pkg::OW'((func == sbc_pkg::PAIR_BB) ? ovb : ovs);
			asgn_c[i] = (func == sbc_pkg::PAIR_BB) ? dd[sbc_pkg::CW-1] : bd[sbc_pkg::CW-1];
		end
		rad_c = (func == sbc_pkg::PAIR_SS)
		      ? sbc_pkg::RW'(size_a[sbc_pkg::CB-1:0]) + sbc_pkg::RW'(size_b[sbc_pkg::CB-1:0])
		      : sbc_pkg::RW'(sr);
	end

	// classification of the squared distance and the overlaps
	always_comb begin
		logic [sbc_pkg::DSW-1:0]      dsq;
		logic                         lt, zer, bs;
		logic [1:0]                   ax;
		logic signed [sbc_pkg::OW-1:0] ovx;
		logic                         sgx;
		dsq = sbc_pkg::DSW'(sq_s2[0]) + sbc_pkg::DSW'(sq_s2[1]) + sbc_pkg::DSW'(sq_s2[2]);
		lt  = dsq < sbc_pkg::DSW'(rsq_s2);
		zer = (dsq == '0);
		bs  = (func_s2 == sbc_pkg::PAIR_BS);
		ax  = sbc_pkg::pick_axis(ov_s2[0], ov_s2[1], ov_s2[2]);
		ovx = (ax == sbc_pkg::AX_X) ? ov_s2[0] : (ax == sbc_pkg::AX_Y) ? ov_s2[1] : ov_s2[2];
		sgx = (ax == sbc_pkg::AX_X) ? asgn_s2[0] : (ax == sbc_pkg::AX_Y) ? asgn_s2[1]
		                                                                 : asgn_s2[2];
		job_c.neg    = dneg_s2 ^ {3{bs}};
		job_c.mag    = dmag_s2;
		job_c.dsq    = dsq[sbc_pkg::SW-1:0];
		job_c.rad    = rad_s2;
		job_c.rest   = rest_s2;
		job_c.fprod  = fprod_s2;
		job_c.sfirst = bs;
		job_c.fix_normal = sbc_pkg::axis_normal(ax, sgx ^ bs);
		job_c.fix_pen    = sbc_pkg::clamp_pen(ovx);
		unique case (func_s2)
			sbc_pkg::PAIR_SS: begin
				job_c.hit        = lt;
				job_c.norm       = !zer;
				job_c.fix_normal = sbc_pkg::axis_normal(sbc_pkg::AX_X, 1'b0);
				job_c.fix_pen    = cpen_s2;
			end
			sbc_pkg::PAIR_BB: begin
				job_c.hit  = (ov_s2[0] > 0) && (ov_s2[1] > 0) && (ov_s2[2] > 0);
				job_c.norm = 1'b0;
			end
			sbc_pkg::PAIR_SB,
			sbc_pkg::PAIR_BS: begin
				job_c.hit  = lt;
				job_c.norm = !zer;
			end
		endcase
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (en) begin
			func_s1  <= func;
			dmag_s1  <= dmag_c;
			dneg_s1  <= dneg_c;
			asgn_s1  <= asgn_c;
			rad_s1   <= rad_c;
			cpen_s1  <= size_a[15:0];
			rest_s1  <= (restitution_a < restitution_b) ? restitution_a : restitution_b;
			fprod_s1 <= friction_a * friction_b;
			for (int i = 0; i < 3; i++) begin
				ov_s1[i] <= ov_c[i];
				ov_s2[i] <= ov_s1[i];
				sq_s2[i] <= dmag_s1[i] * dmag_s1[i];
			end
			func_s2  <= func_s1;
			dmag_s2  <= dmag_s1;
			rsq_s2   <= sbc_pkg::SW'(rad_s1) * sbc_pkg::SW'(rad_s1);
			dneg_s2  <= dneg_s1;
			asgn_s2  <= asgn_s1;
			rad_s2   <= rad_s1;
			cpen_s2  <= cpen_s1;
			rest_s2  <= rest_s1;
			fprod_s2 <= fprod_s1;
			job_s3   <= job_c;
		end
	end

endmodule

[hw/rtl/sbc_queue.sv]
// Small register queue between the front and back ends
module sbc_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sbc_pkg::job_t push_data,
	output logic          full,
	input  logic          pop,
	output sbc_pkg::job_t pop_data,
	output logic          empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int NW = $clog2(DEPTH + 1);

	sbc_pkg::job_t   mem_q [DEPTH];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [NW-1:0]   cnt_q;

	assign full     = (cnt_q == NW'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// pointers wrap at DEPTH, fill count tracks occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + NW'(1);
				2'b01:   cnt_q <= cnt_q - NW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[hw/rtl/sbc_back.sv]
// Back end: square roots, normal division, depth and the output register
module sbc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  sbc_pkg::job_t job,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic          hit,
	output logic [47:0]   contact_normal,
	output logic [15:0]   penetration,
	output logic [15:0]   combined_restitution,
	output logic [15:0]   combined_friction,
	output logic          sphere_first
);

	typedef struct packed {
		sbc_pkg::job_t                job;
		logic [sbc_pkg::REM_W-1:0]    rem;
		logic [sbc_pkg::ROOT_W-1:0]   root;
		logic [sbc_pkg::X_W-1:0]      x;
		logic [sbc_pkg::REM_W-1:0]    frem;
		logic [sbc_pkg::ROOT_W-1:0]   froot;
		logic [sbc_pkg::X_W-1:0]      fx;
	} sq_t;

	typedef struct packed {
		sbc_pkg::job_t                     job;
		logic [sbc_pkg::ROOT_W-1:0]        len;
		logic [2:0][sbc_pkg::NUM_W-1:0]    rem;
		logic [2:0][sbc_pkg::Q_BITS-1:0]   q;
		logic [2:0]                        sat;
		logic [15:0]                       pen;
		logic [15:0]                       froot;
	} dv_t;

	localparam int SQN = sbc_pkg::SQ_STEPS;
	localparam int QN  = sbc_pkg::Q_BITS;

	logic             en;
	logic [SQN:0]     sq_v;
	sq_t              sq_s [SQN+1];
	logic [QN:0]      dv_v;
	dv_t              dv_s [QN+1];
	dv_t              prep_c;
	logic [47:0]      nrm_c;

	logic             out_valid_q;
	logic             hit_q;
	logic [47:0]      normal_q;
	logic [15:0]      pen_q;
	logic [15:0]      rest_q;
	logic [15:0]      fric_q;
	logic             sfirst_q;

	// one enable for the whole back end, held only by a stalled result
	assign en  = !(out_valid_q && out_stall);
	assign pop = en && job_valid;

	assign out_valid            = out_valid_q;
	assign hit                  = hit_q;
	assign contact_normal       = normal_q;
	assign penetration          = pen_q;
	assign combined_restitution = rest_q;
	assign combined_friction    = fric_q;
	assign sphere_first         = sfirst_q;

	// entry of the root pipeline
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s[0].job   <= job;
			sq_s[0].rem   <= '0;
			sq_s[0].root  <= '0;
			sq_s[0].x     <= {job.dsq, {sbc_pkg::XPAD{1'b0}}};
			sq_s[0].frem  <= '0;
			sq_s[0].froot <= '0;
			sq_s[0].fx    <= {job.fprod, {sbc_pkg::F_PAD{1'b0}}};
		end
	end

	// one root digit per stage, length and friction side by side
	for (genvar k = 0; k < SQN; k++) begin : g_sq
		sbc_pkg::sq_res_t a_c;
		sbc_pkg::sq_res_t f_c;
		always_comb begin
			a_c = sbc_pkg::sqrt_step(sq_s[k].rem, sq_s[k].root,
			                         sq_s[k].x[sbc_pkg::X_W-1 -: 2]);
			f_c = sbc_pkg::sqrt_step(sq_s[k].frem, sq_s[k].froot,
			                         sq_s[k].fx[sbc_pkg::X_W-1 -: 2]);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[k+1].job   <= sq_s[k].job;
				sq_s[k+1].rem   <= a_c.rem;
				sq_s[k+1].root  <= a_c.root;
				sq_s[k+1].x     <= sq_s[k].x << 2;
				sq_s[k+1].frem  <= f_c.rem;
				sq_s[k+1].froot <= f_c.root;
				sq_s[k+1].fx    <= sq_s[k].fx << 2;
			end
		end
	end

	// division setup and sphere depth from the length
	always_comb begin
		logic [sbc_pkg::ROOT_W-1:0]       len;
		logic [sbc_pkg::NUM_W-1:0]        num;
		logic signed [sbc_pkg::DEP_W-1:0] dep;
		len = (sq_s[SQN].root == '0) ? sbc_pkg::ROOT_W'(1) : sq_s[SQN].root;
		prep_c.job   = sq_s[SQN].job;
		prep_c.len   = len;
		prep_c.q     = '0;
		prep_c.froot = sq_s[SQN].froot[sbc_pkg::F_SH +: 16];
		for (int i = 0; i < 3; i++) begin
			num = (sbc_pkg::NUM_W'(sq_s[SQN].job.mag[i]) << sbc_pkg::NUM_SH)
			    + sbc_pkg::NUM_W'(len >> 1);
			prep_c.rem[i] = num;
			prep_c.sat[i] = num >= (sbc_pkg::NUM_W'(len) << QN);
		end
		dep = $signed(sbc_pkg::DEP_W'(sq_s[SQN].job.rad) << sbc_pkg::LEN_FRAC)
		    - $signed(sbc_pkg::DEP_W'(len))
		    + $signed(sbc_pkg::DEP_W'(1 << (sbc_pkg::LEN_FRAC - 1)));
		dep = dep >>> sbc_pkg::LEN_FRAC;
		if (!sq_s[SQN].job.norm) begin
			prep_c.pen = sq_s[SQN].job.fix_pen;
		end else if (dep < 0) begin
			prep_c.pen = '0;
		end else if (dep > $signed(sbc_pkg::DEP_W'(sbc_pkg::PEN_MAX))) begin
			prep_c.pen = sbc_pkg::PEN_MAX;
		end else begin
			prep_c.pen = dep[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0] <= prep_c;
		end
	end

	// restoring division, one quotient bit per stage for each lane
	for (genvar k = 0; k < QN; k++) begin : g_dv
		localparam int B = QN - 1 - k;
		dv_t n_c;
		always_comb begin
			logic [sbc_pkg::NUM_W-1:0] t;
			n_c = dv_s[k];
			t   = sbc_pkg::NUM_W'(dv_s[k].len) << B;
			for (int i = 0; i < 3; i++) begin
				if (dv_s[k].rem[i] >= t) begin
					n_c.rem[i]  = dv_s[k].rem[i] - t;
					n_c.q[i][B] = 1'b1;
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[k+1] <= n_c;
			end
		end
	end

	// clamp, sign and pack the normal
	always_comb begin
		logic [15:0] qv;
		for (int i = 0; i < 3; i++) begin
			qv = 16'(dv_s[QN].q[i]);
			if (dv_s[QN].sat[i] || qv > sbc_pkg::NORM_ONE) qv = sbc_pkg::NORM_ONE;
			nrm_c[i*16 +: 16] = dv_s[QN].job.neg[i] ? 16'(-qv) : qv;
		end
	end

	// valid bits for both pipelines and the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v        <= '0;
			dv_v        <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			sq_v        <= {sq_v[SQN-1:0], pop};
			dv_v        <= {dv_v[QN-1:0], sq_v[SQN]};
			out_valid_q <= dv_v[QN];
		end
	end

	// result register; a miss gives all zeros
	always_ff @(posedge clk) begin
		if (en) begin
			hit_q    <= dv_s[QN].job.hit;
			normal_q <= !dv_s[QN].job.hit ? '0
			          : dv_s[QN].job.norm ? nrm_c : dv_s[QN].job.fix_normal;
			pen_q    <= dv_s[QN].job.hit ? dv_s[QN].pen : '0;
			rest_q   <= dv_s[QN].job.hit ? dv_s[QN].job.rest : '0;
			fric_q   <= dv_s[QN].job.hit ? dv_s[QN].froot : '0;
			sfirst_q <= dv_s[QN].job.hit && dv_s[QN].job.sfirst;
		end
	end

endmodule

[hw/rtl/sphere_box_contact_generator.sv]
// Contact test for sphere and axis-aligned box pairs. One pair transfer can
// be taken every clock cycle unless in_stall is high; pairs are independent
// and results come back in order, through 3 front stages, the queue, a root
// entry stage, 25 square-root digit stages, one setup stage, 15 division
// stages and the output register. The pipeline length is set by the
// bit-per-stage square root of the squared distance and the bit-per-stage
// normal division. A stalled result holds the back end only; the front keeps
// taking pairs until the queue between the two fills.
module sphere_box_contact_generator #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [47:0] pos_a,
	input  logic [47:0] pos_b,
	input  logic [47:0] size_a,
	input  logic [47:0] size_b,
	input  logic [15:0] restitution_a,
	input  logic [15:0] restitution_b,
	input  logic [15:0] friction_a,
	input  logic [15:0] friction_b,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        hit,
	output logic [47:0] contact_normal,
	output logic [15:0] penetration,
	output logic [15:0] combined_restitution,
	output logic [15:0] combined_friction,
	output logic        sphere_first
);

	logic          push;
	logic          q_full;
	logic          q_empty;
	logic          pop;
	sbc_pkg::job_t f_job;
	sbc_pkg::job_t b_job;

	sbc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.pos_a         (pos_a),
		.pos_b         (pos_b),
		.size_a        (size_a),
		.size_b        (size_b),
		.restitution_a (restitution_a),
		.restitution_b (restitution_b),
		.friction_a    (friction_a),
		.friction_b    (friction_b),
		.q_full        (q_full),
		.push          (push),
		.job           (f_job)
	);

	sbc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (f_job),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (b_job),
		.empty     (q_empty)
	);

	sbc_back u_back (
		.clk                  (clk),
		.arst_n               (arst_n),
		.job_valid            (!q_empty),
		.job                  (b_job),
		.pop                  (pop),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.hit                  (hit),
		.contact_normal       (contact_normal),
		.penetration          (penetration),
		.combined_restitution (combined_restitution),
		.combined_friction    (combined_friction),
		.sphere_first         (sphere_first)
	);

endmodule

[hw/rtl/sbc_checker.sv]
// Port-level checks on the result channel
module sbc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        hit,
	input logic [47:0] contact_normal,
	input logic [15:0] penetration,
	input logic [15:0] combined_restitution,
	input logic [15:0] combined_friction,
	input logic        sphere_first
);

	// a stalled result stays offered with its hit flag and normal unchanged
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(contact_normal) && $stable(hit))
		else $error("stalled result changed");

	// a miss carries nothing
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> contact_normal == '0 && penetration == '0 &&
		combined_restitution == '0 && combined_friction == '0 && !sphere_first)
		else $error("miss with non-zero fields");

	// a hit always has a direction
	a_dir: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> contact_normal != '0)
		else $error("hit without normal");

	// every normal component lies within plus or minus one
	a_unit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
		$signed(contact_normal[15:0])  <= 16'sh4000 && $signed(contact_normal[15:0])  >= -16'sh4000 &&
		$signed(contact_normal[31:16]) <= 16'sh4000 && $signed(contact_normal[31:16]) >= -16'sh4000 &&
		$signed(contact_normal[47:32]) <= 16'sh4000 && $signed(contact_normal[47:32]) >= -16'sh4000)
		else $error("normal component out of range");

endmodule

bind sphere_box_contact_generator sbc_checker u_sbc_checker (.*);

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

	// Expected contact result for one pair
	typedef struct packed {
		logic        hit;
		logic [47:0] normal;
		logic [15:0] pen;
		logic [15:0] rest;
		logic [15:0] fric;
		logic        sfirst;
	} contact_t;

	// Integer square root, floor
	function automatic longint unsigned int_sqrt(input longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint sgn_comp(input logic [47:0] v, input int i);
		return longint'($signed(v[i*16 +: 16]));
	endfunction

	function automatic longint uns_comp(input logic [47:0] v, input int i);
		return longint'({48'd0, v[i*16 +: 16]});
	endfunction

	function automatic longint abs_l(input longint v);
		return v < 0 ? -v : v;
	endfunction

	// Unit normal from a separation; returns the finer length
	function automatic longint unsigned unit_normal(input longint d[3],
			input longint unsigned dsq, output longint n[3]);
		longint unsigned len, q;
		len = int_sqrt(dsq << 16);
		if (len == 0) len = 1;
		for (int i = 0; i < 3; i++) begin
			q = ((unsigned'(abs_l(d[i])) << 22) + (len >> 1)) / len;
			if (q > 16384) q = 16384;
			n[i] = d[i] < 0 ? -longint'(q) : longint'(q);
		end
		return len;
	endfunction

	// Least-overlap axis; x only if strictly smallest, then y, else z
	function automatic longint least_axis(input longint ov[3], input longint d[3],
			output longint n[3]);
		int ax;
		if (ov[0] < ov[1] && ov[0] < ov[2]) ax = 0;
		else if (ov[1] < ov[0] && ov[1] < ov[2]) ax = 1;
		else ax = 2;
		n[0] = 0; n[1] = 0; n[2] = 0;
		n[ax] = d[ax] < 0 ? -16384 : 16384;
		return ov[ax];
	endfunction

	function automatic bit sphere_vs_box(input longint s[3], input longint r,
			input longint bc[3], input longint e[3], output longint n[3],
			output longint pen);
		longint d[3], bd[3], ov[3], lo, hi, q;
		longint unsigned dsq, len;
		dsq = 0;
		n[0] = 0; n[1] = 0; n[2] = 0;
		pen = 0;
		for (int i = 0; i < 3; i++) begin
			lo = bc[i] - e[i];
			hi = bc[i] + e[i];
			q = s[i];
			if (q < lo) q = lo;
			if (q > hi) q = hi;
			d[i] = s[i] - q;
			dsq += d[i] * d[i];
		end
		if (dsq >= r * r) return 0;
		if (dsq == 0) begin
			for (int i = 0; i < 3; i++) begin
				bd[i] = s[i] - bc[i];
				ov[i] = r + e[i] - abs_l(bd[i]);
			end
			pen = least_axis(ov, bd, n);
		end else begin
			len = unit_normal(d, dsq, n);
			pen = ((r << 8) - longint'(len) + 128) >>> 8;
		end
		return 1;
	endfunction

	function automatic contact_t predict_contact(input sbc_pkg::pair_t kind,
			input logic [47:0] pa_v, pb_v, sa_v, sb_v,
			input logic [15:0] ra, rb, fa, fb);
		contact_t c;
		longint pa[3], pb[3], sa[3], sb[3], d[3], n[3], ov[3], pen, r;
		longint unsigned dsq, len;
		bit h;
		h = 0;
		pen = 0;
		dsq = 0;
		n[0] = 0; n[1] = 0; n[2] = 0;
		c.sfirst = 0;
		for (int i = 0; i < 3; i++) begin
			pa[i] = sgn_comp(pa_v, i);
			pb[i] = sgn_comp(pb_v, i);
			sa[i] = uns_comp(sa_v, i);
			sb[i] = uns_comp(sb_v, i);
			d[i] = pa[i] - pb[i];
		end
		case (kind)
			sbc_pkg::PAIR_SS: begin
				r = sa[0] + sb[0];
				for (int i = 0; i < 3; i++) dsq += d[i] * d[i];
				if (dsq < r * r) begin
					h = 1;
					if (dsq == 0) begin
						n[0] = 16384;
						pen = sa[0];
					end else begin
						len = unit_normal(d, dsq, n);
						pen = ((r << 8) - longint'(len) + 128) >>> 8;
					end
				end
			end
			sbc_pkg::PAIR_BB: begin
				for (int i = 0; i < 3; i++) ov[i] = sa[i] + sb[i] - abs_l(d[i]);
				if (ov[0] > 0 && ov[1] > 0 && ov[2] > 0) begin
					h = 1;
					pen = least_axis(ov, d, n);
				end
			end
			sbc_pkg::PAIR_SB: h = sphere_vs_box(pa, sa[0], pb, sb, n, pen);
			default: begin
				h = sphere_vs_box(pb, sb[0], pa, sa, n, pen);
				if (h) begin
					for (int i = 0; i < 3; i++) n[i] = -n[i];
					c.sfirst = 1;
				end
			end
		endcase
		c.hit = h;
		if (!h) begin
			c.normal = '0; c.pen = '0; c.rest = '0; c.fric = '0; c.sfirst = 0;
			return c;
		end
		if (pen < 0) pen = 0;
		if (pen > 65535) pen = 65535;
		for (int i = 0; i < 3; i++) c.normal[i*16 +: 16] = n[i][15:0];
		c.pen = pen[15:0];
		c.rest = ra < rb ? ra : rb;
		c.fric = 16'(int_sqrt(64'(fa) * 64'(fb)));
		return c;
	endfunction

	// In-order store of expected contacts
	class contact_board;
		contact_t pending[$];
		int errors;

		function void note_pair(contact_t c);
			pending.push_back(c);
		endfunction

		function void check_contact(contact_t got);
			contact_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result transfer", $time);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.hit !== e.hit)
				$display("%0t: hit exp %0h got %0h", $time, e.hit, got.hit);
			if (got.normal !== e.normal)
				$display("%0t: normal exp %h got %h", $time, e.normal, got.normal);
			if (got.pen !== e.pen)
				$display("%0t: penetration exp %h got %h", $time, e.pen, got.pen);
			if (got.rest !== e.rest)
				$display("%0t: restitution exp %h got %h", $time, e.rest, got.rest);
			if (got.fric !== e.fric)
				$display("%0t: friction exp %h got %h", $time, e.fric, got.fric);
			if (got.sfirst !== e.sfirst)
				$display("%0t: sphere_first exp %0h got %0h", $time, e.sfirst, got.sfirst);
			if (got !== e) errors++;
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  func = 0;
	logic [47:0] pos_a = 0, pos_b = 0, size_a = 0, size_b = 0;
	logic [15:0] restitution_a = 0, restitution_b = 0, friction_a = 0, friction_b = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic        hit;
	logic [47:0] contact_normal;
	logic [15:0] penetration, combined_restitution, combined_friction;
	logic        sphere_first;

	int send_idle = 0;
	int recv_idle = 0;
	contact_board board = new();

	sphere_box_contact_generator u_top (.*);

	always #5 clk = ~clk;

	// Result side: random stall and check on each transfer
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			contact_t got;
			got.hit = hit;
			got.normal = contact_normal;
			got.pen = penetration;
			got.rest = combined_restitution;
			got.fric = combined_friction;
			got.sfirst = sphere_first;
			board.check_contact(got);
		end
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	// Drive one pair and hold it until transferred; valid drops on idle or drain
	task automatic send_pair(input logic [1:0] f, input logic [47:0] a, b, sa, sb,
			input logic [15:0] ra, rb, fa, fb);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		func <= f; pos_a <= a; pos_b <= b; size_a <= sa; size_b <= sb;
		restitution_a <= ra; restitution_b <= rb; friction_a <= fa; friction_b <= fb;
		board.note_pair(predict_contact(sbc_pkg::pair_t'(f), a, b, sa, sb, ra, rb, fa, fb));
		do @(posedge clk); while (in_stall);
	endtask

	function automatic logic [15:0] small_coord();
		return 16'($signed($urandom_range(1200)) - 600);
	endfunction

	function automatic logic [47:0] small_vec();
		return {small_coord(), small_coord(), small_coord()};
	endfunction

	function automatic logic [47:0] small_size();
		return {16'($urandom_range(500)), 16'($urandom_range(500)),
			16'($urandom_range(500))};
	endfunction

	// Random pair: mostly close shapes, some full-range noise
	task automatic send_random();
		logic [47:0] a, b, sa, sb;
		int m;
		m = $urandom_range(9);
		a = small_vec();
		if (m < 2) b = a;
		else if (m < 4) b = {a[47:16], a[15:0] + 16'($urandom_range(40))};
		else b = small_vec();
		sa = small_size();
		sb = small_size();
		if (m == 9) begin
			a = 48'({$urandom, $urandom});
			b = 48'({$urandom, $urandom});
			sa = 48'({$urandom, $urandom});
			sb = 48'({$urandom, $urandom});
		end
		send_pair(2'($urandom_range(3)), a, b, sa, sb, 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom));
	endtask

	task automatic drain();
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		logic [47:0] r;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: coincident centres, extremes, ties, no overlap, every kind
		r = 48'h0000_0000_0100;
		for (int k = 0; k < 4; k++) begin
			send_pair(2'(k), '0, '0, r, r, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
			send_pair(2'(k), 48'h0010_0020_0030, '0, 48'h0100_0100_0100,
				48'h0080_0080_0080, 16'h1234, 16'h1233, 16'h0001, 16'hFFFF);
			send_pair(2'(k), 48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000,
				48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'h0, 16'hFFFF, 16'h0, 16'h8000);
			send_pair(2'(k), 48'h0000_0000_0400, '0, r, r, 16'h8000, 16'h8000,
				16'h4000, 16'h4000);
			send_pair(2'(k), 48'hFFF0_FFF0_FFF0, '0, 48'h0020_0020_0020,
				48'h0010_0010_0010, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);
		end
		send_pair(sbc_pkg::PAIR_SB, 48'h0000_0000_0050, '0, 48'h0000_0000_0040,
			48'h0020_0020_0020, 16'h1, 16'h2, 16'h3, 16'h4);
		send_pair(sbc_pkg::PAIR_BS, '0, 48'h0000_0000_0050, 48'h0020_0020_0020,
			48'h0000_0000_0040, 16'h1, 16'h2, 16'h3, 16'h4);
		drain();

		// Random phases with different idle mixes
		for (int ph = 0; ph < 4; ph++) begin
			send_idle = (ph == 1) ? 45 : (ph == 3) ? 36 : 0;
			recv_idle = (ph == 2) ? 45 : (ph == 3) ? 36 : 0;
			for (int i = 0; i < 270; i++) send_random();
			// hold off until everything has come back
			drain();
		end
		recv_idle = 0;
		drain();
		repeat (60) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("Verification failed");
		$finish;
	end

endmodule
